/* rtl/ray_obb_slab_intersect_defines.svh */
// Assertion macros shared by the ray/box slab test RTL
`ifndef RAY_OBB_SLAB_INTERSECT_DEFINES_SVH
`define RAY_OBB_SLAB_INTERSECT_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define RAYOBB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define RAYOBB_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rayobb_pkg.sv */
// Shared constants and controller/datapath types for the ray/box slab test
`default_nettype none
package rayobb_pkg;
	localparam int unsigned AXIS_W  = 26;
	localparam int unsigned POS_W   = 48;
	localparam int unsigned HALF_W  = 47;
	localparam int unsigned DELTA_W = 49;
	localparam int unsigned PROD_W  = 52;
	localparam int unsigned E_W     = 52;
	localparam int unsigned F_W     = 30;
	localparam int unsigned NUM_W   = 53;
	localparam int unsigned DEN_W   = 30;
	localparam int unsigned T_W     = 48;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned DVD_W   = 78;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned IN_W    = 272;
	localparam int unsigned OUT_W   = 48;

	localparam logic [T_W-1:0]    QMAX      = {1'b0, {(T_W-1){1'b1}}};
	localparam logic [HALF_W-1:0] FAR_RESET = 47'd1677721600000;
	localparam logic [F_W-1:0]    EPS_RAW   = 30'd16;
	localparam logic [CNT_W-1:0]  DIV_LAST  = 7'd77;

	// multiplier operand kinds
	localparam logic [1:0] MK_HI  = 2'd0;
	localparam logic [1:0] MK_LO  = 2'd1;
	localparam logic [1:0] MK_DIR = 2'd2;

	// config register indexes
	localparam logic [IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [IDX_W-1:0] CFG_DIR_X    = 3'd3;
	localparam logic [IDX_W-1:0] CFG_DIR_Y    = 3'd4;
	localparam logic [IDX_W-1:0] CFG_DIR_Z    = 3'd5;
	localparam logic [IDX_W-1:0] CFG_FAR      = 3'd6;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_axis;
		logic [1:0] mul_kind;
		logic       par_chk;
		logic       div_start;
		logic       div_sel;
		logic       cap_t0;
		logic       cap_t1;
		logic       upd;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic missed;
		logic last;
		logic parallel;
		logic div_busy;
		logic div_done;
	} dp_sts_t;
endpackage
`default_nettype wire

/* rtl/rayobb_div.sv */
// Restoring divider, one quotient bit per cycle, saturating magnitude result
`default_nettype none
module rayobb_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rayobb_pkg::NUM_W-1:0] num_mag,
	input  wire logic [rayobb_pkg::DEN_W-1:0] den_mag,
	output logic                              busy,
	output logic                              done,
	output logic [rayobb_pkg::T_W-1:0]        quot
);
	import rayobb_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [T_W-1:0]   q_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   try_rem;
	logic [DEN_W:0]   sub_rem;
	logic             ge;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		try_rem = {rem_q, dvd_q[DVD_W-1]};
		ge      = try_rem >= {1'b0, den_q};
		sub_rem = try_rem - {1'b0, den_q};
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_LAST;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifter, remainder, quotient
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {1'b0, num_mag, {FRAC_W{1'b0}}};
			den_q <= den_mag;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? sub_rem[DEN_W-1:0] : try_rem[DEN_W-1:0];
			q_q   <= {q_q[T_W-2:0], ge};
			ovf_q <= ovf_q | q_q[T_W-1];
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quot = (ovf_q || q_q[T_W-1]) ? QMAX : q_q;
endmodule
`default_nettype wire

/* rtl/rayobb_dp.sv */
// Datapath: config registers, shared multiplier, divider, slab bounds, result register
`default_nettype none
module rayobb_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [rayobb_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [rayobb_pkg::POS_W-1:0] cfg_wdata,
	input  wire logic [rayobb_pkg::IN_W-1:0]  in_data,
	input  wire logic                         in_last,
	input  wire rayobb_pkg::dp_cmd_t          cmd,
	output rayobb_pkg::dp_sts_t               sts,
	output logic [rayobb_pkg::OUT_W-1:0]      out_data
);
	import rayobb_pkg::*;

	logic signed [POS_W-1:0]   origin_q [3];
	logic signed [AXIS_W-1:0]  dir_q [3];
	logic [HALF_W-1:0]         far_limit_q;
	logic signed [AXIS_W-1:0]  axis_q [3];
	logic signed [DELTA_W-1:0] delta_q [3];
	logic [HALF_W-1:0]         half_q;
	logic                      last_q;
	logic signed [AXIS_W-1:0]  mul_a;
	logic signed [AXIS_W-1:0]  mul_b;
	logic signed [DELTA_W-1:0] mul_d;
	logic signed [AXIS_W-1:0]  mul_dir;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0]  prod_sh;
	logic                      acc_en_s2;
	logic [1:0]                kind_s2;
	logic signed [E_W-1:0]     e_q;
	logic signed [F_W-1:0]     f_q;
	logic signed [NUM_W-1:0]   e_ext;
	logic signed [NUM_W-1:0]   h_ext;
	logic signed [NUM_W-1:0]   num;
	logic [NUM_W-1:0]          num_mag;
	logic [DEN_W-1:0]          den_mag;
	logic                      neg_q;
	logic [T_W-1:0]            quot;
	logic signed [T_W-1:0]     t_val;
	logic signed [T_W-1:0]     ta_q;
	logic signed [T_W-1:0]     tb_q;
	logic signed [T_W-1:0]     t_lo;
	logic signed [T_W-1:0]     t_hi;
	logic signed [T_W-1:0]     near_nx;
	logic signed [T_W-1:0]     far_nx;
	logic signed [T_W-1:0]     near_q;
	logic signed [T_W-1:0]     far_q;
	logic                      missed_q;
	logic                      hit_q;
	logic [HALF_W-1:0]         dist_q;
	logic                      div_busy;
	logic                      div_done;

	// config registers; far limit write reloads the far bound too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			dir_q[0]    <= '0;
			dir_q[1]    <= '0;
			dir_q[2]    <= '0;
			far_limit_q <= FAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_q[0] <= cfg_wdata;
				CFG_ORIGIN_Y: origin_q[1] <= cfg_wdata;
				CFG_ORIGIN_Z: origin_q[2] <= cfg_wdata;
				CFG_DIR_X:    dir_q[0] <= cfg_wdata[AXIS_W-1:0];
				CFG_DIR_Y:    dir_q[1] <= cfg_wdata[AXIS_W-1:0];
				CFG_DIR_Z:    dir_q[2] <= cfg_wdata[AXIS_W-1:0];
				CFG_FAR:      far_limit_q <= cfg_wdata[HALF_W-1:0];
				default:      ;
			endcase
		end
	end

	// item capture: axis, half extent, center offset from origin
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			axis_q[0]  <= in_data[25:0];
			axis_q[1]  <= in_data[51:26];
			axis_q[2]  <= in_data[77:52];
			half_q     <= in_data[124:78];
			delta_q[0] <= $signed({in_data[172], in_data[172:125]})
				- $signed({origin_q[0][POS_W-1], origin_q[0]});
			delta_q[1] <= $signed({in_data[220], in_data[220:173]})
				- $signed({origin_q[1][POS_W-1], origin_q[1]});
			delta_q[2] <= $signed({in_data[268], in_data[268:221]})
				- $signed({origin_q[2][POS_W-1], origin_q[2]});
			last_q     <= in_last;
		end
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_axis)
			2'd0: begin
				mul_a = axis_q[0]; mul_d = delta_q[0]; mul_dir = dir_q[0];
			end
			2'd1: begin
				mul_a = axis_q[1]; mul_d = delta_q[1]; mul_dir = dir_q[1];
			end
			default: begin
				mul_a = axis_q[2]; mul_d = delta_q[2]; mul_dir = dir_q[2];
			end
		endcase
		case (cmd.mul_kind)
			MK_HI:   mul_b = {mul_d[DELTA_W-1], mul_d[DELTA_W-1:FRAC_W]};
			MK_LO:   mul_b = {2'b00, mul_d[FRAC_W-1:0]};
			default: mul_b = mul_dir;
		endcase
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s2 <= 1'b0;
		end else begin
			acc_en_s2 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		kind_s2 <= cmd.mul_kind;
	end

	assign prod_sh = prod_s2 >>> FRAC_W;

	// accumulate projections e (offset) and f (direction)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q <= '0;
			f_q <= '0;
		end else if (acc_en_s2) begin
			case (kind_s2)
				MK_HI:   e_q <= e_q + prod_s2;
				MK_LO:   e_q <= e_q + prod_sh;
				default: f_q <= f_q + prod_sh[F_W-1:0];
			endcase
		end
	end

	// divider operands: (e +/- h) over f as magnitudes
	always_comb begin
		e_ext   = {e_q[E_W-1], e_q};
		h_ext   = $signed({{(NUM_W-HALF_W){1'b0}}, half_q});
		num     = cmd.div_sel ? (e_ext - h_ext) : (e_ext + h_ext);
		num_mag = num[NUM_W-1] ? -num : num;
		den_mag = f_q[F_W-1] ? -f_q : f_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= num[NUM_W-1] ^ f_q[F_W-1];
		end
	end

	rayobb_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.num_mag (num_mag),
		.den_mag (den_mag),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (quot)
	);

	assign t_val = neg_q ? -$signed(quot) : $signed(quot);

	always_ff @(posedge clk) begin
		if (cmd.cap_t0) ta_q <= t_val;
		if (cmd.cap_t1) tb_q <= t_val;
	end

	// narrowed bounds
	always_comb begin
		t_lo    = (ta_q > tb_q) ? tb_q : ta_q;
		t_hi    = (ta_q > tb_q) ? ta_q : tb_q;
		near_nx = (t_lo > near_q) ? t_lo : near_q;
		far_nx  = (t_hi < far_q) ? t_hi : far_q;
	end

	// box state: bounds and miss flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= '0;
			far_q    <= {1'b0, FAR_RESET};
			missed_q <= 1'b0;
		end else if (cfg_we && cfg_index == CFG_FAR) begin
			far_q <= {1'b0, cfg_wdata[HALF_W-1:0]};
		end else if (cmd.emit) begin
			near_q   <= '0;
			far_q    <= {1'b0, far_limit_q};
			missed_q <= 1'b0;
		end else if (cmd.upd) begin
			near_q <= near_nx;
			far_q  <= far_nx;
			if (near_nx > far_nx || far_nx[T_W-1]) missed_q <= 1'b1;
		end else if (cmd.par_chk) begin
			if (e_ext < -h_ext || e_ext > h_ext) missed_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit_q  <= !missed_q;
			dist_q <= missed_q ? '0 : near_q[HALF_W-1:0];
		end
	end

	assign out_data     = {dist_q, hit_q};
	assign sts.missed   = missed_q;
	assign sts.last     = last_q;
	assign sts.parallel = ($signed(f_q) <= $signed(EPS_RAW)) && ($signed(f_q) >= -$signed(EPS_RAW));
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
endmodule
`default_nettype wire

/* rtl/rayobb_ctrl.sv */
// Controller: sequences multiply steps, two divisions, bound update and result handoff
`default_nettype none
module rayobb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire rayobb_pkg::dp_sts_t sts,
	output rayobb_pkg::dp_cmd_t      cmd
);
	import rayobb_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_ACC  = 4'd2;
	localparam logic [3:0] ST_CHK  = 4'd3;
	localparam logic [3:0] ST_DIV0 = 4'd4;
	localparam logic [3:0] ST_ST1  = 4'd5;
	localparam logic [3:0] ST_DIV1 = 4'd6;
	localparam logic [3:0] ST_UPD  = 4'd7;
	localparam logic [3:0] ST_TAIL = 4'd8;

	logic [3:0] state_q, state_nx;
	logic [1:0] axis_q, axis_nx;
	logic [1:0] kind_q, kind_nx;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		axis_nx  = axis_q;
		kind_nx  = kind_q;
		cmd      = '0;
		cmd.mul_axis = axis_q;
		cmd.mul_kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					axis_nx  = 2'd0;
					kind_nx  = MK_HI;
					state_nx = sts.missed ? ST_TAIL : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (kind_q == MK_DIR) begin
					kind_nx = MK_HI;
					axis_nx = axis_q + 2'd1;
					if (axis_q == 2'd2) state_nx = ST_ACC;
				end else begin
					kind_nx = kind_q + 2'd1;
				end
			end
			ST_ACC: state_nx = ST_CHK;
			ST_CHK: begin
				if (sts.parallel) begin
					cmd.par_chk = 1'b1;
					state_nx    = ST_TAIL;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = ST_DIV0;
				end
			end
			ST_DIV0: begin
				if (sts.div_done) begin
					cmd.cap_t0 = 1'b1;
					state_nx   = ST_ST1;
				end
			end
			ST_ST1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_nx      = ST_DIV1;
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					cmd.cap_t1 = 1'b1;
					state_nx   = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd  = 1'b1;
				state_nx = ST_TAIL;
			end
			ST_TAIL: begin
				if (!sts.last) begin
					state_nx = ST_IDLE;
				end else if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			kind_q      <= MK_HI;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			axis_q  <= axis_nx;
			kind_q  <= kind_nx;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* rtl/ray_obb_slab_intersect.sv */
// Top level: ray against oriented box, slab test, Q24.24 fixed point
// Input stream: one item per slab of a box; s_axis_tlast marks the box's
// last slab. Output stream: one item per box, hit flag and entry distance.
// Config port: origin x/y/z, direction x/y/z, far limit at indexes 0..6;
// the user must write it only while the block is idle (the block does not
// enforce this); a far limit write also reloads the working far bound.
// Timing: one slab item at a time. A slab runs from accept until the next
// item can be taken through: accept, 9 multiply steps through one shared
// 26x26 multiplier plus a drain step, a check, then two 78-step
// one-bit-per-cycle divisions on the shared divider, each followed by a
// done step, with a restart step between them, then update and handoff.
// A slab parallel to the ray skips the divisions and update; any slab after
// a miss goes straight from accept to handoff. The result is registered and
// appears in the cycle after the last slab's handoff.
// Reset clears the box state (near 0, far = far limit, no miss) and the
// config registers to their defaults. A result waits in the output register
// while the receiver stalls; the block can take further slabs meanwhile and
// holds only when a new result would overwrite one not yet taken.
`default_nettype none
`include "ray_obb_slab_intersect_defines.svh"
module ray_obb_slab_intersect (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rayobb_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [rayobb_pkg::POS_W-1:0]  cfg_wdata,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// axis_x, axis_y, axis_z, half_extent, center_x, center_y, center_z, pad
	input  wire logic [rayobb_pkg::IN_W-1:0]   s_axis_tdata,
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// hit, distance
	output logic [rayobb_pkg::OUT_W-1:0]       m_axis_tdata
);
	import rayobb_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rayobb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rayobb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata)
	);

	// checks
	`RAYOBB_ASSERT(a_one_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "item while busy")
	`RAYOBB_ASSERT(a_div_free, cmd.div_start |-> !sts.div_busy, "divider restarted while busy")
	`RAYOBB_ASSERT(a_no_overwrite, cmd.emit |-> !(m_axis_tvalid && !m_axis_tready), "result overwritten")
	`RAYOBB_ASSERT_ALWAYS(a_rst_out, !arst_n |-> !m_axis_tvalid, "output valid during reset")
endmodule
`default_nettype wire

/* sim/ray_obb_slab_intersect_test.sv */
// Testbench for the ray/oriented-box slab intersection block
`timescale 1ns / 100ps
module ray_obb_slab_intersect_test;
	import rayobb_pkg::*;

	localparam int unsigned RUN_LIMIT = 2000000;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam logic signed [AXIS_W-1:0] UNIT = 26'sd16777216;
	// index past the register list, ignored by the block
	localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic signed [AXIS_W-1:0] ax, ay, az;
		logic [HALF_W-1:0]        half;
		logic signed [POS_W-1:0]  cx, cy, cz;
		logic                     last;
	} slab_t;

	typedef struct {
		logic              hit;
		logic [HALF_W-1:0] entry_dist;
	} box_result_t;

	// directed row: slab plus an optional typed-in result
	typedef struct {
		slab_t       slab;
		logic        known;
		box_result_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// axis_x, axis_y, axis_z, half_extent, center_x, center_y, center_z, pad
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// hit, distance
	logic [OUT_W-1:0] m_axis_tdata;

	ray_obb_slab_intersect dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of registers and box state
	logic signed [POS_W-1:0]  ray_org [3];
	logic signed [AXIS_W-1:0] ray_dir [3];
	logic [HALF_W-1:0]        far_lim;
	logic signed [T_W-1:0]    near_t, far_t;
	logic                     box_missed;

	box_result_t box_results_q[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	row_t rows[$];

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at cycle %0d: %s", cycles, what);
	endtask

	// floor(a * b / 2^24)
	function automatic logic signed [79:0] fx_mul(logic signed [AXIS_W-1:0] a,
			logic signed [79:0] b);
		logic signed [79:0] pa, p;
		pa = a;
		p = pa * b;
		return p >>> FRAC_W;
	endfunction

	// num * 2^24 / den, toward zero, saturated
	function automatic logic signed [T_W-1:0] fx_div(logic signed [79:0] num,
			logic signed [79:0] den);
		logic [127:0] na, d, q;
		logic neg;
		neg = (num < 0) != (den < 0);
		na = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = (na << FRAC_W) / d;
		if (q > QMAX)
			q = QMAX;
		return neg ? -q[T_W-1:0] : q[T_W-1:0];
	endfunction

	function automatic void clear_box();
		near_t = '0;
		far_t = {1'b0, far_lim};
		box_missed = 1'b0;
	endfunction

	// narrow the box bounds with one slab; returns 1 when a result is due
	function automatic bit slab_step(slab_t s, output box_result_t r);
		logic signed [79:0] e, f, h, d0, d1, d2;
		logic signed [T_W-1:0] t1, t2, tmp;
		if (!box_missed) begin
			d0 = s.cx; d0 = d0 - ray_org[0];
			d1 = s.cy; d1 = d1 - ray_org[1];
			d2 = s.cz; d2 = d2 - ray_org[2];
			e = fx_mul(s.ax, d0) + fx_mul(s.ay, d1) + fx_mul(s.az, d2);
			f = fx_mul(s.ax, 80'(ray_dir[0])) + fx_mul(s.ay, 80'(ray_dir[1]))
				+ fx_mul(s.az, 80'(ray_dir[2]));
			h = {33'd0, s.half};
			if (f > 16 || f < -16) begin
				t1 = fx_div(e + h, f);
				t2 = fx_div(e - h, f);
				if (t1 > t2) begin
					tmp = t1; t1 = t2; t2 = tmp;
				end
				if (t1 > near_t) near_t = t1;
				if (t2 < far_t) far_t = t2;
				if (near_t > far_t || far_t < 0) box_missed = 1'b1;
			end else if (e < -h || e > h) begin
				box_missed = 1'b1;
			end
		end
		if (!s.last)
			return 0;
		r.hit = !box_missed;
		r.entry_dist = box_missed ? '0 : near_t[HALF_W-1:0];
		clear_box();
		return 1;
	endfunction

	// one register write per edge; the caller drops cfg_we after the last one
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] val);
		cfg_index <= idx;
		cfg_wdata <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		case (idx)
			CFG_ORIGIN_X: ray_org[0] = val;
			CFG_ORIGIN_Y: ray_org[1] = val;
			CFG_ORIGIN_Z: ray_org[2] = val;
			CFG_DIR_X:    ray_dir[0] = val[AXIS_W-1:0];
			CFG_DIR_Y:    ray_dir[1] = val[AXIS_W-1:0];
			CFG_DIR_Z:    ray_dir[2] = val[AXIS_W-1:0];
			CFG_FAR: begin
				far_lim = val[HALF_W-1:0];
				far_t = {1'b0, far_lim};
			end
			default: ;
		endcase
	endtask

	// offer one slab until taken; tvalid stays high inside a burst
	int burst_left = 0;
	task automatic send_slab(input slab_t s, input logic known, input box_result_t kr);
		box_result_t r;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tlast <= s.last;
		s_axis_tdata <= {3'd0, s.cz, s.cy, s.cx, s.half, s.az, s.ay, s.ax};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		if (slab_step(s, r))
			box_results_q.insert(box_results_q.size(), known ? kr : r);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (box_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic signed [AXIS_W-1:0] rand_unitish();
		case ($urandom_range(0, 3))
			0: return UNIT;
			1: return -UNIT;
			2: return 0;
			default: return $signed(26'($urandom_range(0, 33554432))) - UNIT;
		endcase
	endfunction

	// mostly well-formed slabs near the ray, some full-range noise
	function automatic slab_t rand_slab(logic last);
		slab_t s;
		int k;
		if ($urandom_range(0, 9) == 0) begin
			s.ax = 26'($urandom); s.ay = 26'($urandom); s.az = 26'($urandom);
			if (s.ax > UNIT || s.ax < -UNIT) s.ax = s.ax >>> 1;
			if (s.ay > UNIT || s.ay < -UNIT) s.ay = s.ay >>> 1;
			if (s.az > UNIT || s.az < -UNIT) s.az = s.az >>> 1;
			s.half = rand48();
			s.cx = rand48(); s.cy = rand48(); s.cz = rand48();
		end else begin
			s.ax = 0; s.ay = 0; s.az = 0;
			k = $urandom_range(0, 4);
			if (k == 0) s.ax = $urandom_range(0, 1) ? UNIT : -UNIT;
			else if (k == 1) s.ay = $urandom_range(0, 1) ? UNIT : -UNIT;
			else if (k == 2) s.az = $urandom_range(0, 1) ? UNIT : -UNIT;
			else begin
				s.ax = rand_unitish() >>> 1; s.ay = rand_unitish() >>> 1;
				s.az = rand_unitish() >>> 1;
			end
			s.half = $urandom_range(0, 32'h1000_0000);
			s.cx = $signed(48'($urandom_range(0, 32'h8000_0000))) - 48'sh4000_0000;
			s.cy = $signed(48'($urandom_range(0, 32'h8000_0000))) - 48'sh4000_0000;
			s.cz = $signed(48'($urandom_range(0, 32'h8000_0000))) - 48'sh4000_0000;
		end
		s.last = last;
		return s;
	endfunction

	task automatic add_row(input logic signed [AXIS_W-1:0] ax, ay, az,
			input logic [HALF_W-1:0] half, input logic signed [POS_W-1:0] cx, cy, cz,
			input logic last, known, hit);
		row_t r;
		r.slab = '{ax, ay, az, half, cx, cy, cz, last};
		r.known = known;
		r.res = '{hit, '0};
		rows.insert(rows.size(), r);
	endtask

	// result checker
	always @(posedge clk) begin
		box_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (box_results_q.size() == 0) begin
				report("result with none expected");
			end else begin
				want = box_results_q.pop_front();
				if (m_axis_tdata[0] !== want.hit)
					report($sformatf("hit %b, want %b", m_axis_tdata[0], want.hit));
				if (m_axis_tdata[OUT_W-1:1] !== want.entry_dist)
					report($sformatf("distance %h, want %h",
						m_axis_tdata[OUT_W-1:1], want.entry_dist));
			end
		end
	end

	// receiver: long hold-off first, then stall patterns and free stretches
	initial begin
		int unsigned held;
		int mode;
		@(posedge arst_n);
		for (held = 0; held < 3000; held++) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(50, 600)) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 3) != 0;
					default: m_axis_tready <= $urandom_range(0, 4) == 0;
				endcase
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("ray_obb_slab_intersect_test: errors");
			$finish;
		end
	end

	initial begin
		box_result_t none;
		slab_t s;
		int n;
		arst_n <= 1'b0;
		ray_org = '{default: '0};
		ray_dir = '{default: '0};
		far_lim = FAR_RESET;
		clear_box();
		none = '{1'b0, '0};

		// reset state: direction zero, so every slab is parallel
		add_row(UNIT, 0, 0, 47'h100_0000, 0, 0, 0, 1, 1, 1);
		add_row(UNIT, 0, 0, 47'h100_0000, 48'sh500_0000, 0, 0, 1, 1, 0);
		add_row(-UNIT, 0, 0, 47'h7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 0, 0, 1, 1, 1);
		add_row(0, 0, 0, 0, 48'sh8000_0000_0000, 48'sh8000_0000_0000,
			48'sh8000_0000_0000, 1, 1, 1);
		add_row(0, -UNIT, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(0, 0, UNIT, 47'h7FFF_FFFF_FFFF, 0, 0, 0, 1, 1, 0);
		add_row(UNIT, UNIT, UNIT, 47'h7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
			48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 1, 0, 0);
		add_row(-UNIT, -UNIT, -UNIT, 0, 48'sh8000_0000_0000, 0, 48'sh7FFF_FFFF_FFFF,
			1, 0, 0);
		add_row(26'sh155_5555, -26'sh0AA_AAAA, 26'sh0F0_F0F0, 47'h2AAA_AAAA_AAAA,
			48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555, 48'sh0F0F_0F0F_0F0F, 1, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_slab(rows[i].slab, rows[i].known, rows[i].res);
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			// register settings: extremes first, then random rays
			case (ph)
				0: begin
					write_reg(CFG_ORIGIN_X, 0); write_reg(CFG_ORIGIN_Y, 0);
					write_reg(CFG_ORIGIN_Z, 0);
					write_reg(CFG_DIR_X, 48'(UNIT)); write_reg(CFG_DIR_Y, 0);
					write_reg(CFG_DIR_Z, 0);
				end
				1: begin
					write_reg(CFG_ORIGIN_X, 48'h7FFF_FFFF_FFFF);
					write_reg(CFG_ORIGIN_Y, 48'h8000_0000_0000);
					write_reg(CFG_ORIGIN_Z, 48'h7FFF_FFFF_FFFF);
					write_reg(CFG_DIR_X, 48'(-UNIT)); write_reg(CFG_DIR_Y, 48'(UNIT));
					write_reg(CFG_DIR_Z, 48'(-UNIT));
					write_reg(CFG_FAR, 48'h7FFF_FFFF_FFFF);
				end
				2: begin
					write_reg(CFG_FAR, 0);
					write_reg(CFG_ORIGIN_Y, 0);
					write_reg(CFG_UNUSED, rand48());
				end
				default: begin
					write_reg(CFG_ORIGIN_X, $signed(48'($urandom_range(0, 32'h8000_0000)))
						- 48'sh4000_0000);
					write_reg(CFG_ORIGIN_Y, $signed(48'($urandom_range(0, 32'h8000_0000)))
						- 48'sh4000_0000);
					write_reg(CFG_ORIGIN_Z, rand48() >>> ($urandom_range(0, 1) * 16));
					write_reg(CFG_DIR_X, 48'(rand_unitish()));
					write_reg(CFG_DIR_Y, 48'(rand_unitish()));
					write_reg(CFG_DIR_Z, 48'(rand_unitish()));
					write_reg(CFG_FAR, ph == 3 ? 48'(FAR_RESET)
						: 48'({$urandom_range(0, 255), $urandom}));
				end
			endcase
			cfg_we <= 1'b0;
			// boxes of one to four slabs
			n = 0;
			while (n < 120) begin
				int slabs;
				slabs = $urandom_range(1, 4);
				for (int k = 0; k < slabs; k++) begin
					s = rand_slab(k == slabs - 1);
					send_slab(s, 1'b0, none);
					n++;
				end
			end
			settle();
		end

		if (errors == 0)
			$display("ray_obb_slab_intersect_test: clean");
		else
			$display("ray_obb_slab_intersect_test: errors");
		$finish;
	end
endmodule
